// File: design/dtr_pkg.sv
// Shared constants, types and the counter period table for the divider and reloading timer.
package dtr_pkg;

  localparam int DIV_PERIOD = 256;
  localparam int DIV_CLK_W  = $clog2(DIV_PERIOD + 255);
  localparam int CNT_CLK_W  = 11;
  localparam int IRQ_W      = 7;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  localparam logic [1:0] REG_DIV  = 2'd0;
  localparam logic [1:0] REG_CNT  = 2'd1;
  localparam logic [1:0] REG_MOD  = 2'd2;
  localparam logic [1:0] REG_CTRL = 2'd3;

  localparam logic [2:0] CTRL_MASK   = 3'h7;
  localparam int         CTRL_ENABLE = 2;
  localparam logic [IRQ_W-1:0] IRQ_MAX = '1;

  localparam logic [1:0] SEL_1024 = 2'd0;
  localparam logic [1:0] SEL_16   = 2'd1;
  localparam logic [1:0] SEL_64   = 2'd2;
  localparam logic [1:0] SEL_256  = 2'd3;

  typedef struct packed {
    logic accept;
    logic step;
    logic emit;
  } dtr_cmd_t;

  typedef struct packed {
    logic div_due;
    logic cnt_due;
  } dtr_sts_t;

  function automatic logic [CNT_CLK_W-1:0] counter_period(input logic [1:0] sel);
    logic [CNT_CLK_W-1:0] p;
    unique case (sel)
      SEL_1024: p = CNT_CLK_W'(1024);
      SEL_16:   p = CNT_CLK_W'(16);
      SEL_64:   p = CNT_CLK_W'(64);
      SEL_256:  p = CNT_CLK_W'(256);
      default:  p = CNT_CLK_W'(1024);
    endcase
    return p;
  endfunction

endpackage

// File: design/dtr_if.sv
// Valid/ready stream interfaces for the bus operation and result channels.
interface dtr_in_if import dtr_pkg::*; ;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] reg_index;
  logic [7:0] write_data;
  logic [7:0] ticks;

  modport source (output valid, func, reg_index, write_data, ticks, input ready);
  modport sink (input valid, func, reg_index, write_data, ticks, output ready);
endinterface

interface dtr_out_if import dtr_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [7:0]       read_data;
  logic [IRQ_W-1:0] irq_count;

  modport source (output valid, read_data, irq_count, input ready);
  modport sink (input valid, read_data, irq_count, output ready);
endinterface

// File: design/dtr_ctrl.sv
// Controller state machine: accepts a beat, sequences counting steps, emits the result beat.
module dtr_ctrl import dtr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dtr_sts_t sts,
  output dtr_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic due;
  logic slot_free;

  assign due       = sts.div_due | sts.cnt_due;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.step   = 1'b0;
    cmd.emit   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_RUN;
        end
      end
      S_RUN: begin
        if (due) begin
          cmd.step = 1'b1;
        end else if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/dtr_datapath.sv
// Datapath: timer registers, clock accumulators, step logic and result registers.
module dtr_datapath import dtr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  dtr_cmd_t         cmd,
  output dtr_sts_t         sts,
  input  logic [1:0]       func,
  input  logic [1:0]       reg_index,
  input  logic [7:0]       write_data,
  input  logic [7:0]       ticks,
  output logic [7:0]       read_data,
  output logic [IRQ_W-1:0] irq_count
);

  localparam logic [DIV_CLK_W-1:0] DIV_PERIOD_C = DIV_CLK_W'(DIV_PERIOD);

  logic [7:0]           div_val_r, div_val_nxt;
  logic [7:0]           cnt_val_r, cnt_val_nxt;
  logic [7:0]           mod_val_r, mod_val_nxt;
  logic [2:0]           ctrl_r, ctrl_nxt;
  logic [DIV_CLK_W-1:0] div_clk_r, div_clk_nxt;
  logic [CNT_CLK_W-1:0] cnt_clk_r, cnt_clk_nxt;
  logic                 tick_r, tick_nxt;
  logic [7:0]           rd_r, rd_nxt;
  logic [IRQ_W-1:0]     irq_r, irq_nxt;
  logic [7:0]           out_rd_r;
  logic [IRQ_W-1:0]     out_irq_r;
  logic [CNT_CLK_W-1:0] period;
  logic [7:0]           reg_rd;

  assign period      = counter_period(ctrl_r[1:0]);
  assign sts.div_due = (div_clk_r >= DIV_PERIOD_C);
  assign sts.cnt_due = tick_r && ctrl_r[CTRL_ENABLE] && (cnt_clk_r >= period);
  assign read_data   = out_rd_r;
  assign irq_count   = out_irq_r;

  always_comb begin
    unique case (reg_index)
      REG_DIV:  reg_rd = div_val_r;
      REG_CNT:  reg_rd = cnt_val_r;
      REG_MOD:  reg_rd = mod_val_r;
      REG_CTRL: reg_rd = {5'd0, ctrl_r};
      default:  reg_rd = 8'd0;
    endcase
  end

  always_comb begin
    div_val_nxt = div_val_r;
    cnt_val_nxt = cnt_val_r;
    mod_val_nxt = mod_val_r;
    ctrl_nxt    = ctrl_r;
    div_clk_nxt = div_clk_r;
    cnt_clk_nxt = cnt_clk_r;
    tick_nxt    = tick_r;
    rd_nxt      = rd_r;
    irq_nxt     = irq_r;
    if (cmd.accept) begin
      rd_nxt   = 8'd0;
      irq_nxt  = '0;
      tick_nxt = (func == FUNC_TICK);
      case (func)
        FUNC_TICK: begin
          div_clk_nxt = div_clk_r + DIV_CLK_W'(ticks);
          if (ctrl_r[CTRL_ENABLE]) begin
            cnt_clk_nxt = cnt_clk_r + CNT_CLK_W'(ticks);
          end
        end
        FUNC_READ: rd_nxt = reg_rd;
        FUNC_WRITE: begin
          unique case (reg_index)
            REG_DIV:  div_val_nxt = 8'd0;
            REG_CNT:  cnt_val_nxt = write_data;
            REG_MOD:  mod_val_nxt = write_data;
            REG_CTRL: ctrl_nxt = write_data[2:0] & CTRL_MASK;
            default:  ctrl_nxt = ctrl_r;
          endcase
        end
        default: rd_nxt = 8'd0;
      endcase
    end else if (cmd.step) begin
      if (sts.div_due) begin
        div_clk_nxt = div_clk_r - DIV_PERIOD_C;
        div_val_nxt = div_val_r + 8'd1;
      end
      if (sts.cnt_due) begin
        cnt_clk_nxt = cnt_clk_r - period;
        if (cnt_val_r == 8'hFF) begin
          cnt_val_nxt = mod_val_r;
          if (irq_r != IRQ_MAX) begin
            irq_nxt = irq_r + IRQ_W'(1);
          end
        end else begin
          cnt_val_nxt = cnt_val_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_val_r <= 8'd0;
      cnt_val_r <= 8'd0;
      mod_val_r <= 8'd0;
      ctrl_r    <= 3'd0;
      div_clk_r <= '0;
      cnt_clk_r <= '0;
      tick_r    <= 1'b0;
    end else begin
      div_val_r <= div_val_nxt;
      cnt_val_r <= cnt_val_nxt;
      mod_val_r <= mod_val_nxt;
      ctrl_r    <= ctrl_nxt;
      div_clk_r <= div_clk_nxt;
      cnt_clk_r <= cnt_clk_nxt;
      tick_r    <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r  <= rd_nxt;
    irq_r <= irq_nxt;
    if (cmd.emit) begin
      out_rd_r  <= rd_r;
      out_irq_r <= irq_r;
    end
  end

endmodule

// File: design/divider_and_reloading_timer.sv
// Top level: divider and reloading timer with valid/ready bus operation and result channels.
// A read or write result is registered at accept and moved to the result register on emit.
// A tick batch runs N steps, N = max(divider steps, counter steps); the shared
// step logic advances each accumulator by one period per cycle (N is 0 to 79).
// Beats are accepted only when idle; the result register holds a finished beat.
// Reset: synchronous active-low rst_n clears all timer registers and accumulators.
module divider_and_reloading_timer import dtr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  dtr_in_if.sink    in_ch,
  dtr_out_if.source out_ch
);

  dtr_cmd_t cmd;
  dtr_sts_t sts;

  dtr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dtr_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .func       (in_ch.func),
    .reg_index  (in_ch.reg_index),
    .write_data (in_ch.write_data),
    .ticks      (in_ch.ticks),
    .read_data  (out_ch.read_data),
    .irq_count  (out_ch.irq_count)
  );

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!sts.div_due && !sts.cnt_due))
    else $error("timer idle with pending steps");

  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!sts.div_due && !sts.cnt_due))
    else $error("result emitted before steps finished");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("beat accepted while previous beat in progress");

  a_read_no_irq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.read_data != 8'd0)) |-> (out_ch.irq_count == '0))
    else $error("read result carries interrupts");

endmodule

// File: tb/tb_divider_and_reloading_timer.sv
// Self-checking testbench for the divider and reloading timer: random bus beats checked against a predictor.
module tb_divider_and_reloading_timer;
  import dtr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         RANDOM_OPS  = 1150;
  localparam int         CYCLE_LIMIT = 600000;
  localparam int         QUIET_FIRST = 400;
  localparam int         QUIET_LAST  = 650;
  localparam int         PRINT_MAX   = 60;

  typedef struct {
    logic [1:0] func;
    logic [1:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] ticks;
    bit         hold;
  } bus_op_t;

  typedef struct {
    logic [7:0]       read_data;
    logic [IRQ_W-1:0] irq_count;
  } timer_result_t;

  logic clk;
  logic rst_n;

  dtr_in_if  in_ch();
  dtr_out_if out_ch();

  divider_and_reloading_timer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bus_op_t       bus_ops[$];
  timer_result_t due_results[$];
  int            ops_accepted;
  int            errors;
  int            cycles;

  logic [7:0] div_val;
  logic [7:0] cnt_val;
  logic [7:0] mod_val;
  logic [2:0] ctrl_val;
  int         div_clk;
  int         cnt_clk;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic bit quiet_window();
    return ops_accepted >= QUIET_FIRST && ops_accepted < QUIET_LAST;
  endfunction

  task automatic log_mismatch(input string what);
    if (errors < PRINT_MAX) $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic timer_result_t timer_step(input bus_op_t op);
    timer_result_t r;
    int period;
    r.read_data = '0;
    r.irq_count = '0;
    period = 1024;
    case (op.func)
      FUNC_TICK: begin
        div_clk += op.ticks;
        while (div_clk >= DIV_PERIOD) begin
          div_clk -= DIV_PERIOD;
          div_val = div_val + 8'd1;
        end
        if (ctrl_val[CTRL_ENABLE]) begin
          case (ctrl_val[1:0])
            SEL_1024: period = 1024;
            SEL_16:   period = 16;
            SEL_64:   period = 64;
            default:  period = 256;
          endcase
          cnt_clk += op.ticks;
          while (cnt_clk >= period) begin
            cnt_clk -= period;
            cnt_val = cnt_val + 8'd1;
            if (cnt_val == 8'd0) begin
              cnt_val = mod_val;
              if (r.irq_count != IRQ_MAX) r.irq_count = r.irq_count + 1'b1;
            end
          end
        end
      end
      FUNC_READ: begin
        case (op.reg_index)
          REG_DIV: r.read_data = div_val;
          REG_CNT: r.read_data = cnt_val;
          REG_MOD: r.read_data = mod_val;
          default: r.read_data = {5'b0, ctrl_val};
        endcase
      end
      FUNC_WRITE: begin
        case (op.reg_index)
          REG_DIV: div_val = 8'd0;
          REG_CNT: cnt_val = op.write_data;
          REG_MOD: mod_val = op.write_data;
          default: ctrl_val = op.write_data[2:0] & CTRL_MASK;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_op(input logic [1:0] func, input logic [1:0] idx,
                          input logic [7:0] data, input logic [7:0] ticks, input bit hold);
    bus_op_t op;
    op.func       = func;
    op.reg_index  = idx;
    op.write_data = data;
    op.ticks      = ticks;
    op.hold       = hold;
    bus_ops.push_back(op);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        bus_op_t taken;
        taken.func       = in_ch.func;
        taken.reg_index  = in_ch.reg_index;
        taken.write_data = in_ch.write_data;
        taken.ticks      = in_ch.ticks;
        taken.hold       = 1'b0;
        due_results.push_back(timer_step(taken));
        ops_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (bus_ops.size() != 0 && !(bus_ops[0].hold && due_results.size() != 0) &&
            (quiet_window() || $urandom_range(99) >= 15)) begin
          bus_op_t op;
          op = bus_ops.pop_front();
          in_ch.func       <= op.func;
          in_ch.reg_index  <= op.reg_index;
          in_ch.write_data <= op.write_data;
          in_ch.ticks      <= op.ticks;
          in_ch.valid      <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          log_mismatch($sformatf("unexpected beat read_data=%0h irq_count=%0d",
                                 out_ch.read_data, out_ch.irq_count));
        end else begin
          timer_result_t want;
          want = due_results.pop_front();
          if (out_ch.read_data !== want.read_data)
            log_mismatch($sformatf("read_data got %0h want %0h",
                                   out_ch.read_data, want.read_data));
          if (out_ch.irq_count !== want.irq_count)
            log_mismatch($sformatf("irq_count got %0d want %0d",
                                   out_ch.irq_count, want.irq_count));
        end
      end
      out_ch.ready <= quiet_window() || $urandom_range(99) >= 15;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    bus_op_t op;
    int      n;
    int      pick;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_TICK;
    in_ch.reg_index  = REG_DIV;
    in_ch.write_data = '0;
    in_ch.ticks      = '0;
    out_ch.ready     = 1'b0;
    ops_accepted     = 0;
    errors           = 0;
    cycles           = 0;
    div_val  = '0;
    cnt_val  = '0;
    mod_val  = '0;
    ctrl_val = '0;
    div_clk  = 0;
    cnt_clk  = 0;

    // registers after reset
    queue_op(FUNC_READ,  REG_DIV,  8'h00, 8'h00, 1'b0);
    queue_op(FUNC_READ,  REG_CNT,  8'h00, 8'h00, 1'b0);
    queue_op(FUNC_READ,  REG_MOD,  8'h00, 8'h00, 1'b0);
    queue_op(FUNC_READ,  REG_CTRL, 8'h00, 8'h00, 1'b0);
    // control keeps three bits, divider write clears whatever the data
    queue_op(FUNC_WRITE, REG_CNT,  8'hFF, 8'h00, 1'b0);
    queue_op(FUNC_WRITE, REG_MOD,  8'hAA, 8'h00, 1'b0);
    queue_op(FUNC_WRITE, REG_CTRL, 8'hFF, 8'h00, 1'b0);
    queue_op(FUNC_READ,  REG_CTRL, 8'h00, 8'h00, 1'b0);
    queue_op(FUNC_TICK,  REG_DIV,  8'h00, 8'hFF, 1'b0);
    queue_op(FUNC_TICK,  REG_DIV,  8'h00, 8'h00, 1'b0);
    queue_op(FUNC_READ,  REG_DIV,  8'h00, 8'h00, 1'b0);
    queue_op(FUNC_WRITE, REG_DIV,  8'hFF, 8'h00, 1'b1);
    queue_op(FUNC_READ,  REG_DIV,  8'h00, 8'h00, 1'b0);
    // unused function code with every bit set and clear
    queue_op(FUNC_UNUSED, REG_CTRL, 8'hFF, 8'hFF, 1'b0);
    queue_op(FUNC_UNUSED, REG_DIV,  8'h00, 8'h00, 1'b0);
    // disabled counter holds pending clocks
    queue_op(FUNC_WRITE, REG_CTRL, 8'h00, 8'h00, 1'b0);
    queue_op(FUNC_TICK,  REG_DIV,  8'h00, 8'hFF, 1'b0);
    // slow period builds up clocks, then a short period drains them
    queue_op(FUNC_WRITE, REG_CTRL, 8'h04, 8'h00, 1'b0);
    queue_op(FUNC_TICK,  REG_DIV,  8'h00, 8'hFF, 1'b0);
    queue_op(FUNC_TICK,  REG_DIV,  8'h00, 8'hFF, 1'b0);
    queue_op(FUNC_TICK,  REG_DIV,  8'h00, 8'hFF, 1'b0);
    queue_op(FUNC_TICK,  REG_DIV,  8'h00, 8'hFF, 1'b0);
    queue_op(FUNC_WRITE, REG_CTRL, 8'h05, 8'h00, 1'b0);
    queue_op(FUNC_READ,  REG_CNT,  8'h00, 8'h00, 1'b0);
    queue_op(FUNC_TICK,  REG_DIV,  8'h00, 8'h00, 1'b0);
    queue_op(FUNC_READ,  REG_CNT,  8'h00, 8'h00, 1'b0);

    for (n = 0; n < RANDOM_OPS; n++) begin
      pick          = $urandom_range(99);
      op.reg_index  = 2'($urandom_range(3));
      op.write_data = 8'($urandom_range(255));
      op.ticks      = ($urandom_range(4) == 0) ? 8'($urandom_range(15)) :
                                                 8'($urandom_range(255));
      op.hold       = (n == 600) || ($urandom_range(199) == 0);
      if (pick < 45) begin
        op.func = FUNC_TICK;
      end else if (pick < 70) begin
        op.func = FUNC_READ;
      end else if (pick < 95) begin
        op.func = FUNC_WRITE;
        if (op.reg_index == REG_CNT && $urandom_range(1) == 1)
          op.write_data = 8'hF0 | 8'($urandom_range(15));
      end else begin
        op.func = FUNC_UNUSED;
      end
      bus_ops.push_back(op);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (bus_ops.size() != 0 || in_ch.valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
